[rtl/plsi_pkg.sv]
package plsi_pkg;

  // Coordinate and datapath widths
  localparam int CW   = 16;  // query and plane coordinates
  localparam int DW   = 17;  // coordinate differences
  localparam int NW   = 34;  // normal components
  localparam int PW   = 51;  // normal times difference
  localparam int VW   = 53;  // plane evaluation val(p)
  localparam int MNW  = 54;  // denominator magnitude
  localparam int M1W  = 53;  // |val(a)|
  localparam int MDW  = 16;  // |b - a| per axis
  localparam int MULW = 69;  // |val(a)| * |b - a|
  localparam int DVW  = 55;  // divisor, 2 * |den|
  localparam int QW   = 31;  // quotient bits
  localparam int RW   = 87;  // dividend and partial remainder
  localparam int XW   = 24;  // Q16.8 result coordinate
  localparam int CFGW = 48;  // configuration register width
  localparam int CFG_IDX_W = 2;

  localparam logic signed [XW-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [XW-1:0] Q_MIN = -24'sh800000;
  localparam logic [QW-1:0] Q_LIMIT = 31'h4000_0000;

  typedef enum logic [2:0] {
    OP_SIDE2 = 3'd0,
    OP_SIDE3 = 3'd1,
    OP_SEG   = 3'd2,
    OP_LINE  = 3'd3,
    OP_ON    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SIDE_DIFF = 2'd0,
    SIDE_SAME = 2'd1,
    SIDE_ON   = 2'd2
  } side_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST  = 2'd0,
    CFG_SECOND = 2'd1,
    CFG_THIRD  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [CW-1:0] point_a_x;
    logic signed [CW-1:0] point_a_y;
    logic signed [CW-1:0] point_a_z;
    logic signed [CW-1:0] point_b_x;
    logic signed [CW-1:0] point_b_y;
    logic signed [CW-1:0] point_b_z;
    logic signed [CW-1:0] point_c_x;
    logic signed [CW-1:0] point_c_y;
    logic signed [CW-1:0] point_c_z;
  } in_t;

  typedef struct packed {
    logic [1:0]           side_class;
    logic                 point_valid;
    logic signed [XW-1:0] cross_x;
    logic signed [XW-1:0] cross_y;
    logic signed [XW-1:0] cross_z;
    logic                 clipped;
  } out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0]             side;
    logic                   pv;
    logic [2:0]             neg;
    logic [2:0][CW-1:0]     start;
    logic [2:0][MDW-1:0]    md;
    logic [M1W-1:0]         m1;
    logic [MNW-1:0]         mn;
  } cls_t;

endpackage

[rtl/plane_side_and_line_intersection.sv]
// Plane side test and line/plane intersection.
// Configuration: write plane points through cfg_we_i / cfg_idx_i / cfg_data_i
// (index 0, 1, 2 for the first, second and third point; x in bits 15:0,
// y in 31:16, z in 47:32). Writes take effect at once; write only while no
// query is in flight.
// Queries: a transfer happens at each rising edge with start_i high and
// busy_o low. busy_o stays low, so a new query may enter every cycle.
// Results: done_o pulses for one cycle with result_o valid, in query order.
// The rounded intersection offset comes from a 31-stage pipelined restoring
// divider; ahead of it lie the front (normal products, plane evaluation,
// classification), the two-entry queue, the offset multiply and dividend
// setup. Throughput is one query per cycle. The receiver cannot stall; the
// result is present only during the done_o cycle.
// Reset clears the plane points to zero and empties the pipeline; results
// in flight are dropped.
module plane_side_and_line_intersection import plsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFGW-1:0]      cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  in_t                  item_i,
  output logic                 done_o,
  output out_t                 result_o
);

  logic cls_valid, avail, pop;
  cls_t cls, head;

  assign busy_o = 1'b0;

  plsi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .item_i      (item_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls)
  );

  plsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_valid),
    .data_i  (cls),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (head)
  );

  plsi_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .cls_i    (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

[rtl/plsi_front.sv]
module plsi_front import plsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFGW-1:0]      cfg_data_i,
  input  logic                 start_i,
  input  in_t                  item_i,
  output logic                 cls_valid_o,
  output cls_t                 cls_o
);

  logic [CFGW-1:0] pt1_q, pt2_q, pt3_q;
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [DW-1:0] e21 [3];
  logic signed [DW-1:0] e31 [3];
  logic signed [NW-1:0] nrm_d [3];
  logic signed [NW-1:0] nrm_q [3];

  logic in_v_q, s1_v_q, s2_v_q, cls_v_q;
  in_t  in_q;
  logic signed [CW-1:0] qp [3][3];
  logic signed [DW-1:0] dq [3][3];
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  logic [2:0]           s1_op_q, s2_op_q;
  logic signed [CW-1:0] s1_a_q [3];
  logic signed [CW-1:0] s2_a_q [3];
  logic signed [DW-1:0] dl_d [3];
  logic signed [DW-1:0] s1_dl_q [3];
  logic signed [DW-1:0] s2_dl_q [3];
  logic signed [VW-1:0] v_d [3];
  logic signed [VW-1:0] v_q [3];
  cls_t cls_d, cls_q;

  // Capture plane points
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt1_q <= '0;
      pt2_q <= '0;
      pt3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST:  pt1_q <= cfg_data_i;
        CFG_SECOND: pt2_q <= cfg_data_i;
        CFG_THIRD:  pt3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Form the plane normal from the configured points
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p1[j]  = pt1_q[CW*j +: CW];
      p2[j]  = pt2_q[CW*j +: CW];
      p3[j]  = pt3_q[CW*j +: CW];
      e21[j] = DW'(p2[j]) - DW'(p1[j]);
      e31[j] = DW'(p3[j]) - DW'(p1[j]);
    end
    nrm_d[0] = NW'(e31[2]) * NW'(e21[1]) - NW'(e31[1]) * NW'(e21[2]);
    nrm_d[1] = NW'(e31[0]) * NW'(e21[2]) - NW'(e21[0]) * NW'(e31[2]);
    nrm_d[2] = NW'(e21[0]) * NW'(e31[1]) - NW'(e31[0]) * NW'(e21[1]);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) nrm_q[j] <= nrm_d[j];
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      cls_v_q <= 1'b0;
    end else begin
      in_v_q  <= start_i;
      s1_v_q  <= in_v_q;
      s2_v_q  <= s1_v_q;
      cls_v_q <= s2_v_q;
    end
  end

  // Products of normal and offsets from the first plane point
  always_comb begin
    qp[0][0] = in_q.point_a_x; qp[0][1] = in_q.point_a_y; qp[0][2] = in_q.point_a_z;
    qp[1][0] = in_q.point_b_x; qp[1][1] = in_q.point_b_y; qp[1][2] = in_q.point_b_z;
    qp[2][0] = in_q.point_c_x; qp[2][1] = in_q.point_c_y; qp[2][2] = in_q.point_c_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dq[i][j]     = DW'(qp[i][j]) - DW'(p1[j]);
        prod_d[i][j] = PW'(nrm_q[j]) * PW'(dq[i][j]);
      end
    end
    for (int j = 0; j < 3; j++) dl_d[j] = DW'(qp[1][j]) - DW'(qp[0][j]);
  end

  // Sum into val(p) per point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_d[i] = VW'(prod_q[i][0]) + VW'(prod_q[i][1]) + VW'(prod_q[i][2]);
    end
  end

  // Classify by side and prepare magnitudes for the divider
  always_comb begin
    logic z0, z1, z2, ps0, ps1, ps2, ng0, ng1, ng2;
    logic signed [MNW-1:0] den;
    side_e s2, s3;
    z0  = (v_q[0] == '0);
    z1  = (v_q[1] == '0);
    z2  = (v_q[2] == '0);
    ng0 = v_q[0][VW-1];
    ng1 = v_q[1][VW-1];
    ng2 = v_q[2][VW-1];
    ps0 = !ng0 && !z0;
    ps1 = !ng1 && !z1;
    ps2 = !ng2 && !z2;
    den = MNW'(v_q[0]) - MNW'(v_q[1]);

    if (z0 && z1)                          s2 = SIDE_ON;
    else if ((ps0 && ps1) || (ng0 && ng1)) s2 = SIDE_SAME;
    else                                   s2 = SIDE_DIFF;
    if (z0 && z1 && z2)                                 s3 = SIDE_ON;
    else if ((ps0 && ps1 && ps2) || (ng0 && ng1 && ng2)) s3 = SIDE_SAME;
    else                                                s3 = SIDE_DIFF;

    cls_d      = '0;
    cls_d.m1   = ng0 ? M1W'(-v_q[0]) : M1W'(v_q[0]);
    cls_d.mn   = den[MNW-1] ? MNW'(-den) : MNW'(den);
    for (int j = 0; j < 3; j++) begin
      cls_d.start[j] = s2_a_q[j];
      cls_d.md[j]    = s2_dl_q[j][DW-1] ? MDW'(-s2_dl_q[j]) : MDW'(s2_dl_q[j]);
      cls_d.neg[j]   = ng0 ^ s2_dl_q[j][DW-1] ^ den[MNW-1];
    end
    case (op_e'(s2_op_q))
      OP_SIDE2: cls_d.side = s2;
      OP_SIDE3: cls_d.side = s3;
      OP_SEG: begin
        cls_d.side = s2;
        cls_d.pv   = (s2 == SIDE_DIFF);
      end
      OP_LINE: begin
        cls_d.side = s2;
        cls_d.pv   = (den != '0);
      end
      OP_ON:   cls_d.side = z0 ? SIDE_ON : SIDE_DIFF;
      default: cls_d.side = SIDE_DIFF;
    endcase
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (start_i) in_q <= item_i;
    prod_q  <= prod_d;
    s1_op_q <= in_q.opcode;
    s2_op_q <= s1_op_q;
    for (int j = 0; j < 3; j++) begin
      s1_a_q[j]  <= qp[0][j];
      s2_a_q[j]  <= s1_a_q[j];
      s1_dl_q[j] <= dl_d[j];
      s2_dl_q[j] <= s1_dl_q[j];
      v_q[j]     <= v_d[j];
    end
    cls_q <= cls_d;
  end

  assign cls_valid_o = cls_v_q;
  assign cls_o       = cls_q;

endmodule

[rtl/plsi_fifo.sv]
module plsi_fifo import plsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t data_i,
  input  logic pop_i,
  output logic avail_o,
  output cls_t data_o
);

  cls_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = pop_i && (cnt_q != 2'd0);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

[rtl/plsi_back.sv]
module plsi_back import plsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic avail_i,
  input  cls_t cls_i,
  output logic pop_o,
  output logic done_o,
  output out_t result_o
);

  typedef struct packed {
    logic [1:0]           side;
    logic                 pv;
    logic [2:0]           neg;
    logic [2:0][CW-1:0]   start;
    logic [2:0][MULW-1:0] prod;
    logic [MNW-1:0]       mn;
  } mul_t;

  typedef struct packed {
    logic [1:0]          side;
    logic                pv;
    logic [2:0]          neg;
    logic [2:0][CW-1:0]  start;
    logic [2:0]          ovf;
    logic [DVW-1:0]      dvs;
    logic [2:0][RW-1:0]  rem;
    logic [2:0][QW-1:0]  quo;
  } dv_t;

  logic b0_v_q;
  mul_t b0_q, b0_d;
  logic stg_v_q [QW+1];
  dv_t  stg_q [QW+1];
  dv_t  b1_d;
  logic done_q;
  out_t res_q, res_d;

  // Take the queue head in every cycle that it is available
  assign pop_o = avail_i;

  // Multiply |val(a)| by |b - a| per axis
  always_comb begin
    b0_d       = '0;
    b0_d.side  = cls_i.side;
    b0_d.pv    = cls_i.pv;
    b0_d.neg   = cls_i.neg;
    b0_d.start = cls_i.start;
    b0_d.mn    = cls_i.mn;
    for (int j = 0; j < 3; j++) begin
      b0_d.prod[j] = MULW'(cls_i.m1) * MULW'(cls_i.md[j]);
    end
  end

  // Build rounding dividend, divisor and overflow flag
  always_comb begin
    logic [RW-1:0] lim;
    b1_d       = '0;
    b1_d.side  = b0_q.side;
    b1_d.pv    = b0_q.pv;
    b1_d.neg   = b0_q.neg;
    b1_d.start = b0_q.start;
    b1_d.dvs   = {b0_q.mn, 1'b0};
    lim        = RW'(b1_d.dvs) << QW;
    for (int j = 0; j < 3; j++) begin
      b1_d.rem[j] = (RW'(b0_q.prod[j]) << 9) + RW'(b0_q.mn);
      b1_d.ovf[j] = (b1_d.rem[j] >= lim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q     <= 1'b0;
      stg_v_q[0] <= 1'b0;
    end else begin
      b0_v_q     <= avail_i;
      stg_v_q[0] <= b0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q     <= b0_d;
    stg_q[0] <= b1_d;
  end

  // Restoring division, one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    dv_t nx;
    always_comb begin
      logic [RW-1:0] dsh;
      nx  = stg_q[k];
      dsh = RW'(stg_q[k].dvs) << (QW - 1 - k);
      for (int j = 0; j < 3; j++) begin
        if (stg_q[k].rem[j] >= dsh) begin
          nx.rem[j] = stg_q[k].rem[j] - dsh;
          nx.quo[j] = {stg_q[k].quo[j][QW-2:0], 1'b1};
        end else begin
          nx.quo[j] = {stg_q[k].quo[j][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_v_q[k+1] <= 1'b0;
      end else begin
        stg_v_q[k+1] <= stg_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k+1] <= nx;
    end
  end

  // Add offset to start, saturate and assemble the result
  always_comb begin
    logic signed [XW-1:0] cx [3];
    logic                 clp [3];
    logic signed [QW+1:0] t;
    logic signed [QW+1:0] qs;
    dv_t f;
    f = stg_q[QW];
    for (int j = 0; j < 3; j++) begin
      qs = $signed({2'b00, f.quo[j]});
      t  = ((QW+2)'($signed(f.start[j])) <<< 8) + (f.neg[j] ? -qs : qs);
      cx[j]  = '0;
      clp[j] = 1'b0;
      if (f.pv) begin
        if (f.ovf[j] || (f.quo[j] > Q_LIMIT)) begin
          cx[j]  = f.neg[j] ? Q_MIN : Q_MAX;
          clp[j] = 1'b1;
        end else if (t > (QW+2)'(Q_MAX)) begin
          cx[j]  = Q_MAX;
          clp[j] = 1'b1;
        end else if (t < (QW+2)'(Q_MIN)) begin
          cx[j]  = Q_MIN;
          clp[j] = 1'b1;
        end else begin
          cx[j] = XW'(t);
        end
      end
    end
    res_d.side_class  = f.side;
    res_d.point_valid = f.pv;
    res_d.cross_x     = cx[0];
    res_d.cross_y     = cx[1];
    res_d.cross_z     = cx[2];
    res_d.clipped     = clp[0] | clp[1] | clp[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stg_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[tb/sv/plane_side_and_line_intersection_tb.sv]
`timescale 1ns / 100ps

module plane_side_and_line_intersection_tb;
  import plsi_pkg::*;

  localparam int LATENCY   = 38;
  localparam int DRAIN_MAX = 400;
  localparam int WDOG_MAX  = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFGW-1:0]      cfg_data_i;
  logic                 start_i;
  logic                 busy_o;
  in_t                  item_i;
  logic                 done_o;
  out_t                 result_o;

  plane_side_and_line_intersection dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_o, .item_i, .done_o, .result_o
  );

  // Plane points as seen by the predictor
  logic [CFGW-1:0] plane_pt [3];

  out_t expected_q [$];
  int   fail_cnt;
  int   idle_cycles;
  bit   quiet_mode;

  // Directed rows: item and, where obvious, the result it must give
  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic longint coord(logic [CFGW-1:0] pt, int axis);
    logic signed [15:0] c;
    c = pt[axis*16 +: 16];
    return longint'(c);
  endfunction

  // Rounded, saturated Q16.8 intersection coordinate
  function automatic longint cross_q168(longint start, longint v1, longint delta,
                                        longint den, inout bit clip);
    logic signed [127:0] num, dn, q, t;
    if (v1 == 0 || delta == 0) return start * 256;
    num = 128'(v1) * 128'(delta) * 256;
    dn  = 128'(den);
    if ((num < 0) != (dn < 0)) begin
      q = -(((num < 0 ? -num : num) * 2 + (dn < 0 ? -dn : dn)) / ((dn < 0 ? -dn : dn) * 2));
    end else begin
      q = ((num < 0 ? -num : num) * 2 + (dn < 0 ? -dn : dn)) / ((dn < 0 ? -dn : dn) * 2);
    end
    t = 128'(start) * 256 + q;
    if (t > 128'sd8388607) begin
      clip = 1'b1;
      return 8388607;
    end
    if (t < -128'sd8388608) begin
      clip = 1'b1;
      return -8388608;
    end
    return longint'(t);
  endfunction

  function automatic out_t predict_query(in_t it);
    longint p [3][3];
    longint q [3][3];
    longint nrm [3];
    longint v [3];
    longint den, cx [3];
    int     pos, neg, zer, n;
    bit     clip;
    out_t   r;
    r = '0;
    clip = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) p[i][j] = coord(plane_pt[i], j);
    q[0][0] = it.point_a_x; q[0][1] = it.point_a_y; q[0][2] = it.point_a_z;
    q[1][0] = it.point_b_x; q[1][1] = it.point_b_y; q[1][2] = it.point_b_z;
    q[2][0] = it.point_c_x; q[2][1] = it.point_c_y; q[2][2] = it.point_c_z;
    nrm[0] = (p[2][2]-p[0][2])*(p[1][1]-p[0][1]) - (p[2][1]-p[0][1])*(p[1][2]-p[0][2]);
    nrm[1] = -((p[1][0]-p[0][0])*(p[2][2]-p[0][2]) - (p[2][0]-p[0][0])*(p[1][2]-p[0][2]));
    nrm[2] = (p[1][0]-p[0][0])*(p[2][1]-p[0][1]) - (p[2][0]-p[0][0])*(p[1][1]-p[0][1]);
    for (int i = 0; i < 3; i++)
      v[i] = nrm[0]*(q[i][0]-p[0][0]) + nrm[1]*(q[i][1]-p[0][1]) + nrm[2]*(q[i][2]-p[0][2]);
    n = (it.opcode == OP_SIDE3) ? 3 : 2;
    pos = 0; neg = 0; zer = 0;
    for (int i = 0; i < n; i++) begin
      if (v[i] == 0) zer++;
      else if (v[i] > 0) pos++;
      else neg++;
    end
    case (it.opcode)
      OP_SIDE2, OP_SIDE3, OP_SEG, OP_LINE: begin
        r.side_class = (zer == n) ? SIDE_ON : ((pos == n || neg == n) ? SIDE_SAME : SIDE_DIFF);
        if (it.opcode == OP_SEG || it.opcode == OP_LINE) begin
          den = v[0] - v[1];
          r.point_valid = (it.opcode == OP_SEG) ? (r.side_class == SIDE_DIFF) : (den != 0);
          if (r.point_valid) begin
            for (int j = 0; j < 3; j++)
              cx[j] = cross_q168(q[0][j], v[0], q[1][j] - q[0][j], den, clip);
            r.cross_x = cx[0][23:0];
            r.cross_y = cx[1][23:0];
            r.cross_z = cx[2][23:0];
            r.clipped = clip;
          end
        end
      end
      OP_ON: r.side_class = (v[0] == 0) ? SIDE_ON : SIDE_DIFF;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Count idle cycles for the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("%0t watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, result_o);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (result_o.side_class !== want.side_class ||
            result_o.point_valid !== want.point_valid ||
            result_o.cross_x !== want.cross_x || result_o.cross_y !== want.cross_y ||
            result_o.cross_z !== want.cross_z || result_o.clipped !== want.clipped) begin
          $display("%0t mismatch expected %h actual %h", $time, want, result_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_plane(cfg_idx_e idx, logic [CFGW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    plane_pt[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_plane(logic [CFGW-1:0] a, logic [CFGW-1:0] b, logic [CFGW-1:0] c);
    write_plane(CFG_FIRST, a);
    write_plane(CFG_SECOND, b);
    write_plane(CFG_THIRD, c);
  endtask

  // Drop start, wait for the queue to drain, then for the pipeline
  task automatic settle();
    int n;
    n = 0;
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_q.size() != 0 && n < 100 * DRAIN_MAX) begin
      @(posedge clk_i);
      n++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Present one query; hold start until the transfer happens
  task automatic send_query(in_t it, bit typed, out_t want);
    @(negedge clk_i);
    while (!quiet_mode && $urandom_range(99) < 16) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(typed ? want : predict_query(it));
  endtask

  function automatic logic [CFGW-1:0] pack_pt(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(64)) - 16'd32;
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic in_t rand_query(int mode);
    in_t it;
    it = '0;
    it.opcode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    it.point_a_x = rand_coord(mode); it.point_a_y = rand_coord(mode);
    it.point_a_z = rand_coord(mode); it.point_b_x = rand_coord(mode);
    it.point_b_y = rand_coord(mode); it.point_b_z = rand_coord(mode);
    it.point_c_x = rand_coord(mode); it.point_c_y = rand_coord(mode);
    it.point_c_z = rand_coord(mode);
    return it;
  endfunction

  initial begin
    row_t rows [$];
    row_t rw;
    int   mode;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_FIRST;
    cfg_data_i = '0;
    start_i    = 1'b0;
    item_i     = '0;
    fail_cnt   = 0;
    idle_cycles = 0;
    quiet_mode = 1'b0;
    plane_pt[0] = '0; plane_pt[1] = '0; plane_pt[2] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Degenerate plane after reset: every point on it, nothing valid
    rw.typed = 1'b1;
    rw.want = '0; rw.want.side_class = SIDE_ON;
    rw.item = '0; rw.item.opcode = OP_SIDE2; rw.item.point_a_x = 16'h7FFF; rows.push_back(rw);
    rw.item.opcode = OP_SIDE3; rw.item.point_c_z = 16'h8000; rows.push_back(rw);
    rw.item.opcode = OP_SEG; rows.push_back(rw);
    rw.item.opcode = OP_LINE; rows.push_back(rw);
    rw.item.opcode = OP_ON; rows.push_back(rw);
    rw.want = '0; rw.item = '1; rw.item.opcode = 3'd5; rows.push_back(rw);
    rw.item.opcode = 3'd7; rows.push_back(rw);
    foreach (rows[i]) send_query(rows[i].item, rows[i].typed, rows[i].want);
    settle();

    // Plane z = 0 with small normal, then extremes of the coordinates
    load_plane(pack_pt(0, 0, 0), pack_pt(1, 0, 0), pack_pt(0, 1, 0));
    rows.delete();
    rw.typed = 1'b0;
    for (int op = 0; op < 6; op++) begin
      rw.item = '0; rw.item.opcode = 3'(op);
      rw.item.point_a_z = 16'sd5; rw.item.point_b_z = -16'sd3; rw.item.point_b_x = 16'sd7;
      rw.item.point_c_z = 16'sd0; rows.push_back(rw);
      rw.item.point_a_z = 16'h7FFF; rw.item.point_b_z = 16'h7FFE;
      rw.item.point_a_x = 16'h8000; rw.item.point_b_x = 16'h7FFF; rows.push_back(rw);
    end
    // Segment touching the plane at one end, and a line crossing it outside the segment
    rw.item = '0; rw.item.opcode = OP_SEG; rw.item.point_b_z = 16'sd4; rows.push_back(rw);
    rw.item = '0; rw.item.opcode = OP_LINE; rw.item.point_a_z = 16'sd1;
    rw.item.point_b_z = 16'sd3; rw.item.point_b_x = 16'sd1; rows.push_back(rw);
    foreach (rows[i]) send_query(rows[i].item, rows[i].typed, rows[i].want);
    settle();

    // Random phases over several planes, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_plane(48'h7FFF_7FFF_7FFF, 48'h8000_8000_7FFF, 48'h8000_7FFF_8000);
        1: load_plane(48'h8000_8000_8000, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_7FFF);
        2: load_plane(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 48'h0001_0000_FFFF);
        default: load_plane(48'($urandom) | (48'($urandom) << 32),
                            48'($urandom) | (48'($urandom) << 32),
                            48'($urandom) | (48'($urandom) << 32));
      endcase
      quiet_mode = (ph == 3);
      for (int k = 0; k < 300; k++) begin
        mode = $urandom_range(9);
        mode = (mode < 5) ? 0 : ((mode < 9) ? 1 : 2);
        send_query(rand_query(mode), 1'b0, '0);
      end
      settle();
    end

    if (expected_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
